@@ rtl/sharp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sharp_pkg: shared types and constants of the 3x3 sharpen filter
// Line store depth, register widths, pixel and result word types.
// ----------------------------------------------------------------------------
package sharp_pkg;

    // Line store geometry.
    localparam int MAX_WIDTH = 2048;
    localparam int XW        = $clog2(MAX_WIDTH);

    // Register widths and limits.
    localparam int WIDTH_W      = 12;
    localparam int HEIGHT_W     = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int HEIGHT_LIMIT = 4096;

    // Width used for the row-length compare; holds MAX_WIDTH and the register.
    localparam int CW = ((XW + 1) > WIDTH_W) ? (XW + 1) : WIDTH_W;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

    // Configuration register indexes.
    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    // Color channels, one filter lane each.
    localparam int NCH      = 3;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic [7:0]           t_sample;
    typedef t_sample [NCH-1:0]    t_pix;    // indexed by channel
    typedef t_pix [2:0]           t_col;    // 0 top, 1 middle, 2 bottom
    typedef t_sample [2:0]        t_tap3;   // one channel of one column

    // Both line stores share one address, so they live in one word.
    typedef struct packed {
        t_pix upper;
        t_pix middle;
    } t_store;

    typedef struct packed {
        t_sample red;
        t_sample green;
        t_sample blue;
        logic    last_of_run;
        logic    frame_done;
    } t_result;

    // Up to two result words handed to the output queue in one cycle.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);

endpackage
`default_nettype wire

@@ rtl/sharp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sharp_if: stream and configuration channels of the sharpen filter
// Valid/ready channels for pixels in, results out and register writes.
// ----------------------------------------------------------------------------
interface sharp_pix_if import sharp_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample red_in;
    t_sample green_in;
    t_sample blue_in;
    logic    is_padding;

    modport source (output valid, red_in, green_in, blue_in, is_padding, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, is_padding, output ready);
endinterface

interface sharp_res_if import sharp_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample red_out;
    t_sample green_out;
    t_sample blue_out;
    logic    last_of_run;
    logic    frame_done;

    modport source (output valid, red_out, green_out, blue_out, last_of_run, frame_done,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, last_of_run, frame_done,
                    output ready);
endinterface

interface sharp_cfg_if import sharp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_cfg_reg              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/sharp_line_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sharp_line_store: the two previous image rows
// One word per column holds the upper and middle row pixels, registered read.
// ----------------------------------------------------------------------------
module sharp_line_store import sharp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [XW-1:0] i_rd_addr,
    output t_store        o_rd_data,
    input  logic          i_wr_en,
    input  logic [XW-1:0] i_wr_addr,
    input  t_store        i_wr_data
);

    t_store r_mem [MAX_WIDTH];
    t_store r_rd_data;

    // Write port; contents are undefined until a column is first written.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

@@ rtl/sharp_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sharp_lane: sharpen kernel for one color channel
// Computes clamp(9 * center - sum of the eight neighbors, 0, 255).
// ----------------------------------------------------------------------------
module sharp_lane import sharp_pkg::*; (
    input  t_tap3   i_left,
    input  t_tap3   i_center,
    input  t_tap3   i_right,
    output t_sample o_value
);

    logic [10:0]        w_ring;
    logic [11:0]        w_center9;
    logic signed [12:0] w_diff;

    // Sum of the eight neighbors, at most 8 * 255.
    assign w_ring = 11'(i_left[0]) + 11'(i_left[1]) + 11'(i_left[2])
                  + 11'(i_right[0]) + 11'(i_right[1]) + 11'(i_right[2])
                  + 11'(i_center[0]) + 11'(i_center[2]);

    // Nine times the center sample as a shift and an add.
    assign w_center9 = {1'b0, i_center[1], 3'b000} + 12'(i_center[1]);

    assign w_diff = $signed({1'b0, w_center9}) - $signed({2'b00, w_ring});

    // Clamp to the unsigned 8-bit range.
    always_comb begin
        if (w_diff[12]) begin
            o_value = '0;
        end else if (w_diff > 13'sd255) begin
            o_value = 8'hFF;
        end else begin
            o_value = w_diff[7:0];
        end
    end

endmodule
`default_nettype wire

@@ rtl/sharp_merge.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sharp_merge: result queue of the sharpen filter
// Packs the lane outputs of up to two results per pixel into one word stream.
// ----------------------------------------------------------------------------
module sharp_merge import sharp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_push         i_push,
    output logic          o_room,
    sharp_res_if.source   o_res
);

    t_result          r_mem [QDEPTH];
    logic [QPW-1:0]   r_head;
    logic [QPW-1:0]   r_tail;
    logic [QPW:0]     r_count;
    logic             w_pop;
    t_result          w_head_word;

    assign w_pop  = o_res.valid && o_res.ready;
    // Room for the largest push, not counting a pop in the same cycle.
    assign o_room = r_count <= (QPW + 1)'(QDEPTH - 2);

    // Queue storage; the second word of a pair goes one place after the first.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_tail] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_tail + QPW'(1)] <= i_push.second;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + QPW'(i_push.count);
            r_count <= r_count + (QPW + 1)'(i_push.count) - (QPW + 1)'(w_pop);
            if (w_pop) begin
                r_head <= r_head + QPW'(1);
            end
        end
    end

    // The word at the head of the queue drives the output channel.
    assign w_head_word       = r_mem[r_head];
    assign o_res.valid       = r_count != '0;
    assign o_res.red_out     = w_head_word.red;
    assign o_res.green_out   = w_head_word.green;
    assign o_res.blue_out    = w_head_word.blue;
    assign o_res.last_of_run = w_head_word.last_of_run;
    assign o_res.frame_done  = w_head_word.frame_done;

    // A push never overfills the queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |->
            ((QPW + 2)'(r_count) + (QPW + 2)'(i_push.count) <= (QPW + 2)'(QDEPTH)))
        else $error("result queue overflow");

    // The push count never takes the unused code three.
    a_push_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.count != 2'd3)
        else $error("invalid push count");

endmodule
`default_nettype wire

@@ rtl/sharpen_3x3_rgb_filter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sharpen_3x3_rgb_filter_unit: streaming 3x3 sharpen for RGB888 pixels
// Line stores, a 3x3 window, one filter lane per channel and a result queue.
// ----------------------------------------------------------------------------
// A result word passes the window stage and the result queue before it is offered.
// Throughput: one pixel per cycle while the queue has room, set by the single line
// store read port and the one-word-per-cycle output; a row's last pixel yields two
// words and the next row's first pixel yields none, so the queue absorbs the pair.
// Reset (synchronous, active low) clears the counters, window and queue and
// loads 640 x 480; the line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sharpen_3x3_rgb_filter_unit import sharp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sharp_cfg_if.sink   i_cfg,
    sharp_pix_if.sink   i_pix,
    sharp_res_if.source o_res
);

    typedef struct packed {
        logic emit_first;   // result for the column left of this pixel
        logic emit_second;  // end of row: result for the row's last column
        logic frame_done;
        logic row_ge1;
        logic row_ge2;
        logic col_zero;
    } t_ctl;

    // Configuration registers.
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;

    // Position of the next pixel.
    logic [XW-1:0]       r_col;
    logic [HEIGHT_W-1:0] r_row;

    // Window stage.
    logic                r_b_valid;
    t_ctl                r_b_ctl;
    t_pix                r_b_bot;
    logic [XW-1:0]       r_b_addr;
    t_col                r_win_left;
    t_col                r_win_center;

    logic [CW-1:0]       w_width_eff;
    logic [HEIGHT_W-1:0] w_height_eff;
    logic                w_accept;
    logic                w_b_fire;
    logic                w_room;
    logic                w_endrow;
    logic                w_pad_row;
    logic                w_pad;
    t_ctl                w_ctl;
    t_pix                w_bot;
    t_store              w_rd_data;
    t_store              w_wr_data;
    t_col                w_cur;
    t_col                w_next_left;
    t_sample             w_val_a [NCH];
    t_sample             w_val_b [NCH];
    t_result             w_res_a;
    t_result             w_res_b;
    t_push               w_push;

    // Register writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg.data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg.data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register values as used, clamped to the supported frame size.
    always_comb begin
        if (CW'(r_width) < CW'(2)) begin
            w_width_eff = CW'(2);
        end else if (CW'(r_width) > CW'(MAX_WIDTH)) begin
            w_width_eff = CW'(MAX_WIDTH);
        end else begin
            w_width_eff = CW'(r_width);
        end
        if (r_height < HEIGHT_W'(2)) begin
            w_height_eff = HEIGHT_W'(2);
        end else if (r_height > HEIGHT_W'(HEIGHT_LIMIT)) begin
            w_height_eff = HEIGHT_W'(HEIGHT_LIMIT);
        end else begin
            w_height_eff = r_height;
        end
    end

    // Input handshake: a new pixel enters whenever the window stage is empty or moves on.
    assign w_b_fire    = r_b_valid && w_room;
    assign i_pix.ready = !r_b_valid || w_b_fire;
    assign w_accept    = i_pix.valid && i_pix.ready;

    // Position decode of the incoming pixel.
    assign w_endrow  = CW'(r_col) >= (w_width_eff - CW'(1));
    assign w_pad_row = r_row >= w_height_eff;
    assign w_pad     = i_pix.is_padding || w_pad_row;

    assign w_ctl.emit_first  = (r_row != '0) && (r_col != '0);
    assign w_ctl.emit_second = w_endrow && (r_row != '0);
    assign w_ctl.frame_done  = w_endrow && w_pad_row;
    assign w_ctl.row_ge1     = r_row != '0;
    assign w_ctl.row_ge2     = r_row >= HEIGHT_W'(2);
    assign w_ctl.col_zero    = r_col == '0;

    assign w_bot[CH_RED]   = w_pad ? '0 : i_pix.red_in;
    assign w_bot[CH_GREEN] = w_pad ? '0 : i_pix.green_in;
    assign w_bot[CH_BLUE]  = w_pad ? '0 : i_pix.blue_in;

    // Column and row counters; the padding row's last pixel ends the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            if (w_endrow) begin
                r_col <= '0;
                r_row <= w_pad_row ? '0 : (r_row + HEIGHT_W'(1));
            end else begin
                r_col <= r_col + XW'(1);
            end
        end
    end

    // Window stage control and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_b_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b_ctl  <= w_ctl;
            r_b_bot  <= w_bot;
            r_b_addr <= r_col;
        end
    end

    // Line stores: read at acceptance, shifted down one row when the window moves.
    assign w_wr_data.upper  = w_rd_data.middle;
    assign w_wr_data.middle = r_b_bot;

    sharp_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_b_fire),
        .i_wr_addr (r_b_addr),
        .i_wr_data (w_wr_data)
    );

    // Current column; rows above the image read as zero.
    assign w_cur[0] = r_b_ctl.row_ge2 ? w_rd_data.upper  : '0;
    assign w_cur[1] = r_b_ctl.row_ge1 ? w_rd_data.middle : '0;
    assign w_cur[2] = r_b_bot;

    // Left column after the shift; a new row starts from the zero border.
    assign w_next_left = r_b_ctl.col_zero ? '0 : r_win_center;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= '0;
            r_win_center <= '0;
        end else if (w_b_fire) begin
            r_win_left   <= w_next_left;
            r_win_center <= w_cur;
        end
    end

    // One lane per channel for each of the two possible results.
    for (genvar ch = 0; ch < NCH; ch++) begin : g_lane
        t_tap3 w_a_left;
        t_tap3 w_a_center;
        t_tap3 w_a_right;
        t_tap3 w_b_left;
        t_tap3 w_b_center;

        for (genvar k = 0; k < 3; k++) begin : g_tap
            assign w_a_left[k]   = r_win_left[k][ch];
            assign w_a_center[k] = r_win_center[k][ch];
            assign w_a_right[k]  = w_cur[k][ch];
            assign w_b_left[k]   = w_next_left[k][ch];
            assign w_b_center[k] = w_cur[k][ch];
        end

        sharp_lane u_lane_a (
            .i_left   (w_a_left),
            .i_center (w_a_center),
            .i_right  (w_a_right),
            .o_value  (w_val_a[ch])
        );

        // The row's last column sees the zero border on its right.
        sharp_lane u_lane_b (
            .i_left   (w_b_left),
            .i_center (w_b_center),
            .i_right  ('0),
            .o_value  (w_val_b[ch])
        );
    end

    // Merge the lane outputs into result words.
    assign w_res_a.red         = w_val_a[CH_RED];
    assign w_res_a.green       = w_val_a[CH_GREEN];
    assign w_res_a.blue        = w_val_a[CH_BLUE];
    assign w_res_a.last_of_run = !r_b_ctl.emit_second;
    assign w_res_a.frame_done  = 1'b0;

    assign w_res_b.red         = w_val_b[CH_RED];
    assign w_res_b.green       = w_val_b[CH_GREEN];
    assign w_res_b.blue        = w_val_b[CH_BLUE];
    assign w_res_b.last_of_run = 1'b1;
    assign w_res_b.frame_done  = r_b_ctl.frame_done;

    assign w_push.count  = w_b_fire ? (2'(r_b_ctl.emit_first) + 2'(r_b_ctl.emit_second))
                                    : 2'd0;
    assign w_push.first  = r_b_ctl.emit_first ? w_res_a : w_res_b;
    assign w_push.second = w_res_b;

    sharp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_res   (o_res)
    );

    // The line store is never read and written at one column in one cycle.
    a_store_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_b_fire && w_accept) |-> (r_b_addr != r_col))
        else $error("line store read and write collide");

    // The padding row's last pixel starts a new frame.
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_endrow && w_pad_row) |=> ((r_col == '0) && (r_row == '0)))
        else $error("counters did not wrap at frame end");

    // A stalled window stage keeps its pixel.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !w_b_fire) |=> (r_b_valid && $stable(r_b_addr) && $stable(r_b_bot)))
        else $error("window stage lost a stalled pixel");

endmodule
`default_nettype wire

@@ tb/tb_sharpen_3x3_rgb_filter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sharpen_3x3_rgb_filter_unit: self-checking bench of the 3x3 sharpen
// A short table of hand-checked frames, two frames that start at the register
// extremes and are cut short partway, and many small random frames. Every
// result word is compared against the table or a behavioral model of the line
// stores and window kept inside the bench.
// ----------------------------------------------------------------------------
module tb_sharpen_3x3_rgb_filter_unit import sharp_pkg::*; ();

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PIXELS  = 1750;
    localparam int EXTREME_PIXELS = 24;
    localparam int DIR_ROWS       = 18;

    // One row of the directed table; typed rows carry their expected color.
    typedef struct {
        t_sample r;
        t_sample g;
        t_sample b;
        logic    pad;
        logic    typed;
        int      nres;
        t_sample er;
        t_sample eg;
        t_sample eb;
        logic    done;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    sharp_cfg_if cfg_ch ();
    sharp_pix_if pix_ch ();
    sharp_res_if res_ch ();

    sharpen_3x3_rgb_filter_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    // Model state: registers, line stores, the two older window columns and position.
    logic [WIDTH_W-1:0]  width_reg  = WIDTH_RESET;
    logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
    t_pix                upper_line  [MAX_WIDTH];
    t_pix                middle_line [MAX_WIDTH];
    t_col                left_col   = '0;
    t_col                center_col = '0;
    int                  col_pos    = 0;
    int                  row_pos    = 0;

    t_result expected_words [$];
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    int      random_pixels  = 0;
    bit      no_idle        = 1'b0;

    // Frames at width 2, height 2. The first two have row-uniform colors, so each
    // result equals its own pixel after the clamp. The third has a padding flag
    // inside the image and an unflagged item in the padding row.
    t_dir_row dir_table [DIR_ROWS] = '{
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 2, 8'd255, 8'd255, 8'd255, 1'b0},
        '{8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 2, 8'd255, 8'd255, 8'd255, 1'b1},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b1, 0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b1, 0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{8'd0,   8'd255, 8'd0,   1'b0, 1'b1, 0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{8'd0,   8'd255, 8'd0,   1'b0, 1'b1, 2, 8'd255, 8'd0,   8'd0,   1'b0},
        '{8'd0,   8'd0,   8'd255, 1'b0, 1'b1, 0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{8'd0,   8'd0,   8'd255, 1'b0, 1'b1, 2, 8'd0,   8'd255, 8'd0,   1'b1},
        '{8'd10,  8'd20,  8'd30,  1'b0, 1'b0, 0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{8'd40,  8'd50,  8'd60,  1'b0, 1'b0, 0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{8'd200, 8'd200, 8'd200, 1'b1, 1'b0, 0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{8'd30,  8'd30,  8'd30,  1'b0, 1'b0, 0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{8'd90,  8'd90,  8'd90,  1'b0, 1'b0, 0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{8'd1,   8'd2,   8'd3,   1'b1, 1'b0, 0, 8'd0,   8'd0,   8'd0,   1'b0}
    };

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int eff_width();
        int w;
        w = int'(width_reg);
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = int'(height_reg);
        if (h < 2) h = 2;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        return h;
    endfunction

    // Kernel: 9 times the center minus the eight neighbors, clamped to 0..255.
    function automatic t_result sharpen_at(t_col left, t_col center, t_col right);
        int      acc;
        t_sample chan [NCH];
        t_result res;
        for (int ch = 0; ch < NCH; ch++) begin
            acc = 9 * int'(center[1][ch]) - int'(center[0][ch]) - int'(center[2][ch]);
            for (int k = 0; k < 3; k++) begin
                acc = acc - int'(left[k][ch]) - int'(right[k][ch]);
            end
            if (acc < 0) acc = 0;
            if (acc > 255) acc = 255;
            chan[ch] = 8'(acc);
        end
        res.red         = chan[CH_RED];
        res.green       = chan[CH_GREEN];
        res.blue        = chan[CH_BLUE];
        res.last_of_run = 1'b0;
        res.frame_done  = 1'b0;
        return res;
    endfunction

    // Advances the model by one accepted pixel and returns the words it causes.
    task automatic advance_sharpen(input t_pix px, input logic pad, output int n,
                                   output t_result first, output t_result second);
        int      w;
        int      h;
        int      x;
        int      y;
        t_col    cur;
        t_result outs [2];
        w = eff_width();
        h = eff_height();
        x = col_pos;
        y = row_pos;
        if (x >= MAX_WIDTH) x = MAX_WIDTH - 1;

        // Rows above the image read as zero; the padding row reads as zero.
        cur[0] = (y >= 2) ? upper_line[x] : '0;
        cur[1] = (y >= 1) ? middle_line[x] : '0;
        cur[2] = (pad || y >= h) ? '0 : px;
        upper_line[x]  = middle_line[x];
        middle_line[x] = cur[2];

        n = 0;
        outs[0] = '0;
        outs[1] = '0;
        if (y >= 1 && x >= 1) begin
            outs[n] = sharpen_at(left_col, center_col, cur);
            n++;
        end
        left_col   = (x == 0) ? '0 : center_col;
        center_col = cur;

        // End of row: flush the last column against a zero column.
        if (x >= w - 1) begin
            if (y >= 1) begin
                outs[n] = sharpen_at(left_col, center_col, '0);
                outs[n].frame_done = (y >= h);
                n++;
            end
            col_pos = 0;
            row_pos = (y >= h) ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
        end
        if (n > 0) outs[n-1].last_of_run = 1'b1;
        first  = outs[0];
        second = outs[1];
    endtask

    // Offers one pixel word, waits for it to be taken, then runs the model.
    task automatic push_pixel(input t_pix px, input logic pad, input bit queue_prediction);
        int      n;
        t_result first;
        t_result second;
        while (!no_idle && $urandom_range(99) < 19) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.red_in     <= px[CH_RED];
        pix_ch.green_in   <= px[CH_GREEN];
        pix_ch.blue_in    <= px[CH_BLUE];
        pix_ch.is_padding <= pad;
        do @(posedge i_clk); while (!pix_ch.ready);
        advance_sharpen(px, pad, n, first, second);
        if (queue_prediction) begin
            if (n > 0) expected_words.push_back(first);
            if (n > 1) expected_words.push_back(second);
        end
    endtask

    // Samples lean toward both rails so that both ends of the clamp are hit.
    function automatic t_sample rand_sample();
        int pick;
        pick = int'($urandom_range(3));
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random_pixel();
        t_pix px;
        logic pad;
        for (int ch = 0; ch < NCH; ch++) px[ch] = rand_sample();
        if (row_pos >= eff_height()) pad = ($urandom_range(99) < 75);
        else pad = ($urandom_range(99) < 4);
        push_pixel(px, pad, 1'b1);
        random_pixels++;
    endtask

    // Sends pixels until the model wraps back to the top left corner.
    task automatic send_frame();
        do send_random_pixel(); while (col_pos != 0 || row_pos != 0);
    endtask

    // Drops valid, lets every expected word come out, then lets the pipe settle.
    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) width_reg = value[WIDTH_W-1:0];
        else height_reg = value;
        @(posedge i_clk);
    endtask

    // Result side: ready drops about one time in five, except in the no-idle stretch.
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= no_idle || ($urandom_range(99) >= 19);
        end
    end

    // Each taken result word is matched against the oldest expected word.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.red         = res_ch.red_out;
            got.green       = res_ch.green_out;
            got.blue        = res_ch.blue_out;
            got.last_of_run = res_ch.last_of_run;
            got.frame_done  = res_ch.frame_done;
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: r%0d g%0d b%0d last %0b done %0b",
                             got.red, got.green, got.blue, got.last_of_run, got.frame_done);
            end else begin
                want = expected_words.pop_front();
                if (got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue || got.last_of_run !== want.last_of_run
                        || got.frame_done !== want.frame_done) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: want r%0d g%0d b%0d last %0b done %0b, %s",
                                 want.red, want.green, want.blue, want.last_of_run,
                                 want.frame_done,
                                 $sformatf("got r%0d g%0d b%0d last %0b done %0b",
                                           got.red, got.green, got.blue,
                                           got.last_of_run, got.frame_done));
                end
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any word moving.
    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus.
    initial begin
        t_pix    px;
        t_result want;
        int      span;

        i_rst_n           <= 1'b0;
        pix_ch.valid      <= 1'b0;
        pix_ch.red_in     <= '0;
        pix_ch.green_in   <= '0;
        pix_ch.blue_in    <= '0;
        pix_ch.is_padding <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_IMAGE_WIDTH;
        cfg_ch.data       <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Values below the minimum act as a 2 x 2 image.
        write_reg(CFG_IMAGE_WIDTH, 13'd0);
        write_reg(CFG_IMAGE_HEIGHT, 13'd1);

        // Directed frames.
        for (int i = 0; i < DIR_ROWS; i++) begin
            px[CH_RED]   = dir_table[i].r;
            px[CH_GREEN] = dir_table[i].g;
            px[CH_BLUE]  = dir_table[i].b;
            push_pixel(px, dir_table[i].pad, !dir_table[i].typed);
            if (dir_table[i].typed) begin
                for (int k = 0; k < dir_table[i].nres; k++) begin
                    want.red         = dir_table[i].er;
                    want.green       = dir_table[i].eg;
                    want.blue        = dir_table[i].eb;
                    want.last_of_run = (k == dir_table[i].nres - 1);
                    want.frame_done  = dir_table[i].done && (k == dir_table[i].nres - 1);
                    expected_words.push_back(want);
                end
            end
        end

        // Each frame starts with one register at its largest value and the other low,
        // and is cut short by a smaller value once part of a row or a few rows are in.
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 13'd4095);
        write_reg(CFG_IMAGE_HEIGHT, 13'd0);
        repeat (EXTREME_PIXELS) send_random_pixel();
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 13'd6);
        send_frame();
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 13'd1);
        write_reg(CFG_IMAGE_HEIGHT, 13'd8191);
        repeat (EXTREME_PIXELS) send_random_pixel();
        wait_idle();
        write_reg(CFG_IMAGE_HEIGHT, 13'd3);
        send_frame();

        // Random frames, some with a register change partway through.
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            no_idle = (random_pixels >= 700 && random_pixels < 1100);
            wait_idle();
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(99) < 10) write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(1)));
                else if ($urandom_range(99) < 12)
                    write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(17, 64)));
                else write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(2, 16)));
            end
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(99) < 10) write_reg(CFG_IMAGE_HEIGHT, 13'($urandom_range(1)));
                else write_reg(CFG_IMAGE_HEIGHT, 13'($urandom_range(2, 6)));
            end
            if ($urandom_range(99) < 15) begin
                // Narrowing only, so no line store entry is read before it is written.
                span = eff_width() * eff_height();
                repeat ($urandom_range(1, span)) send_random_pixel();
                wait_idle();
                if ($urandom_range(1) == 0)
                    write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(2, eff_width())));
                else write_reg(CFG_IMAGE_HEIGHT, 13'($urandom_range(0, 8)));
            end
            send_frame();
        end
        no_idle = 1'b0;

        wait_idle();
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
